// File: hw/rtl/rmq_pkg.sv
// shared types for the rotation matrix to quaternion pipeline
package rmq_pkg;

  // which component takes the root: x, y, z pivot or positive trace
  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } piv_t;

  typedef struct packed {
    logic valid;
    piv_t piv;
  } ctl_t;

endpackage

// File: hw/rtl/rmq_pre.sv
// front stage: trace, pivot choice, root argument and component sums
module rmq_pre #(
  parameter int W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [W-1:0]        m00,
  input  logic signed [W-1:0]        m01,
  input  logic signed [W-1:0]        m02,
  input  logic signed [W-1:0]        m10,
  input  logic signed [W-1:0]        m11,
  input  logic signed [W-1:0]        m12,
  input  logic signed [W-1:0]        m20,
  input  logic signed [W-1:0]        m21,
  input  logic signed [W-1:0]        m22,
  output rmq_pkg::ctl_t              ctl,
  output logic [2*W-1:0]             n,
  output logic [4*(W+1)-1:0]         d
);
  import rmq_pkg::*;

  localparam int TW = W + 3;
  localparam int DW = W + 1;
  localparam int NW = 2 * W;
  localparam int F  = W - 2;
  localparam logic signed [TW-1:0] ONE = TW'(1) << F;

  logic signed [TW-1:0] e00, e11, e22, tr, t;
  logic signed [DW-1:0] a, b, c, sxy, sxz, syz;
  logic signed [DW-1:0] dx, dy, dz, dw;
  logic signed [W-1:0]  mbig;
  piv_t                 pv;
  logic [NW-1:0]        n_next;

  always_comb begin
    e00 = TW'(m00);
    e11 = TW'(m11);
    e22 = TW'(m22);
    tr  = e00 + e11 + e22;
    a   = DW'(m12) - DW'(m21);
    b   = DW'(m20) - DW'(m02);
    c   = DW'(m01) - DW'(m10);
    sxy = DW'(m01) + DW'(m10);
    sxz = DW'(m02) + DW'(m20);
    syz = DW'(m12) + DW'(m21);
    if (m00 < m11) begin
      pv   = PIV_Y;
      mbig = m11;
    end else begin
      pv   = PIV_X;
      mbig = m00;
    end
    if (mbig < m22) pv = PIV_Z;
    if (tr > 0) pv = PIV_W;
    dx = '0;
    dy = '0;
    dz = '0;
    dw = '0;
    t  = tr + ONE;
    case (pv)
      PIV_X: begin
        t  = e00 - e11 - e22 + ONE;
        dw = a;
        dy = sxy;
        dz = sxz;
      end
      PIV_Y: begin
        t  = e11 - e22 - e00 + ONE;
        dw = b;
        dz = syz;
        dx = sxy;
      end
      PIV_Z: begin
        t  = e22 - e00 - e11 + ONE;
        dw = c;
        dx = sxz;
        dy = syz;
      end
      default: begin
        dx = a;
        dy = b;
        dz = c;
      end
    endcase
    n_next = (t > 0) ? (NW'(t) << F) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= in_valid;
      ctl.piv   <= pv;
      n         <= n_next;
      d         <= {dw, dz, dy, dx};
    end
  end

endmodule

// File: hw/rtl/rmq_sqrt.sv
// pipelined integer square root, one result bit per stage
module rmq_sqrt #(
  parameter int W  = 16,
  parameter int SW = 68
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rmq_pkg::ctl_t     ctl_in,
  input  logic [2*W-1:0]    n_in,
  input  logic [SW-1:0]     side_in,
  output rmq_pkg::ctl_t     ctl_out,
  output logic [W-1:0]      s_out,
  output logic [SW-1:0]     side_out
);
  import rmq_pkg::*;

  localparam int NW = 2 * W;

  ctl_t           ctl_q  [W+1];
  logic [NW-1:0]  n_q    [W+1];
  logic [W+1:0]   rem_q  [W+1];
  logic [W-1:0]   root_q [W+1];
  logic [SW-1:0]  side_q [W+1];

  assign ctl_q[0]  = ctl_in;
  assign n_q[0]    = n_in;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W+1:0] remsh, trial;
    logic         ge;

    always_comb begin
      remsh = {rem_q[k][W-1:0], n_q[k][NW-1:NW-2]};
      trial = {root_q[k], 2'b01};
      ge    = (remsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k+1] <= '0;
      end else if (en) begin
        ctl_q[k+1]  <= ctl_q[k];
        n_q[k+1]    <= n_q[k] << 2;
        rem_q[k+1]  <= ge ? (remsh - trial) : remsh;
        root_q[k+1] <= {root_q[k][W-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign ctl_out  = ctl_q[W];
  assign s_out    = root_q[W];
  assign side_out = side_q[W];

endmodule

// File: hw/rtl/rmq_recip.sv
// pipelined restoring divide of a fixed power of two by the root
module rmq_recip #(
  parameter int W  = 16,
  parameter int SW = 68
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rmq_pkg::ctl_t       ctl_in,
  input  logic [W-1:0]        s_in,
  input  logic [SW-1:0]       side_in,
  output rmq_pkg::ctl_t       ctl_out,
  output logic [W-1:0]        s_out,
  output logic [2*W-5:0]      r_out,
  output logic [SW-1:0]       side_out
);
  import rmq_pkg::*;

  localparam int QW = 2 * W - 4;

  ctl_t           ctl_q  [QW+1];
  logic [W-1:0]   s_q    [QW+1];
  logic [W-1:0]   rem_q  [QW+1];
  logic [QW-1:0]  quo_q  [QW+1];
  logic [SW-1:0]  side_q [QW+1];

  assign ctl_q[0]  = ctl_in;
  assign s_q[0]    = s_in;
  assign rem_q[0]  = '0;
  assign quo_q[0]  = '0;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [W:0] remsh;
    logic       ge;

    // dividend has a single one bit at its top
    always_comb begin
      remsh = {rem_q[k], 1'(k == 0)};
      ge    = (remsh >= {1'b0, s_q[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k+1] <= '0;
      end else if (en) begin
        ctl_q[k+1]  <= ctl_q[k];
        s_q[k+1]    <= s_q[k];
        rem_q[k+1]  <= ge ? W'(remsh - {1'b0, s_q[k]}) : W'(remsh);
        quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign ctl_out  = ctl_q[QW];
  assign s_out    = s_q[QW];
  assign r_out    = quo_q[QW];
  assign side_out = side_q[QW];

endmodule

// File: hw/rtl/rmq_post.sv
// back stages: scale the sums by the reciprocal, saturate, place the half root
module rmq_post #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rmq_pkg::ctl_t       ctl_in,
  input  logic [W-1:0]        s_in,
  input  logic [2*W-5:0]      r_in,
  input  logic [4*(W+1)-1:0]  d_in,
  output rmq_pkg::ctl_t       ctl_out,
  output logic signed [W-1:0] q [4]
);
  import rmq_pkg::*;

  localparam int DW = W + 1;
  localparam int QW = 2 * W - 4;
  localparam int PW = DW + QW;
  localparam int F  = W - 2;
  localparam logic [PW-1:0] QMAXP = PW'({1'b0, {(W-1){1'b1}}});

  ctl_t           ctl_a;
  logic [W-1:0]   s_a;
  logic [PW-1:0]  prod_a [4];
  logic           neg_a  [4];

  // multiply stage
  for (genvar l = 0; l < 4; l++) begin : g_mul
    logic signed [DW-1:0] dl;
    logic [DW-1:0]        mag;

    always_comb begin
      dl  = d_in[l*DW +: DW];
      mag = dl[DW-1] ? DW'(-dl) : DW'(dl);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_a[l] <= PW'(mag) * PW'(r_in);
        neg_a[l]  <= dl[DW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a <= ctl_in;
      s_a   <= s_in;
    end
  end

  // shift, saturate and select stage
  for (genvar l = 0; l < 4; l++) begin : g_sat
    logic [PW-1:0]       p, np;
    logic signed [W-1:0] v;

    always_comb begin
      p  = prod_a[l] >> F;
      np = -p;
      if (neg_a[l]) begin
        v = (p > QMAXP + PW'(1)) ? {1'b1, {(W-1){1'b0}}} : np[W-1:0];
      end else begin
        v = (p > QMAXP) ? {1'b0, {(W-1){1'b1}}} : p[W-1:0];
      end
      if (ctl_a.piv == piv_t'(l)) v = {1'b0, s_a[W-1:1]};
      if (s_a == '0) v = '0;
    end

    always_ff @(posedge clk) begin
      if (en) q[l] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_a;
    end
  end

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to unit quaternion, fully pipelined fixed point
// the pipeline has 1 front stage, DATA_WIDTH root stages, 2*DATA_WIDTH-4 reciprocal
//   stages and 2 multiply and saturate stages
// throughput: one matrix per cycle; a stall at the output freezes every stage at once
// reset: synchronous, clears the valid bits of all stages, data registers keep contents
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] quat_x,
  output logic signed [DATA_WIDTH-1:0] quat_y,
  output logic signed [DATA_WIDTH-1:0] quat_z,
  output logic signed [DATA_WIDTH-1:0] quat_w
);
  import rmq_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int DW = W + 1;
  localparam int SW = 4 * DW;

  // whole pipeline advances together unless the last beat is held
  logic en;

  ctl_t                ctl_pre, ctl_sq, ctl_rc, ctl_po;
  logic [2*W-1:0]      n_pre;
  logic [SW-1:0]       d_pre, d_sq, d_rc;
  logic [W-1:0]        s_sq, s_rc;
  logic [2*W-5:0]      r_rc;
  logic signed [W-1:0] q [4];

  assign en       = !ctl_po.valid || out_ready;
  assign in_ready = en;

  // trace test, pivot and the argument of the root, shifted to Q.2F
  rmq_pre #(.W(W)) u_pre (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .ctl(ctl_pre), .n(n_pre), .d(d_pre)
  );

  // s = floor(sqrt(t * 2^F)), a bit per stage
  rmq_sqrt #(.W(W), .SW(SW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .ctl_in(ctl_pre), .n_in(n_pre), .side_in(d_pre),
    .ctl_out(ctl_sq), .s_out(s_sq), .side_out(d_sq)
  );

  // r = floor(2^(2F-1) / s), i.e. 0.5/s in Q.F
  rmq_recip #(.W(W), .SW(SW)) u_recip (
    .clk(clk), .rst(rst), .en(en),
    .ctl_in(ctl_sq), .s_in(s_sq), .side_in(d_sq),
    .ctl_out(ctl_rc), .s_out(s_rc), .r_out(r_rc), .side_out(d_rc)
  );

  // sign-magnitude products, truncated toward zero, then clamped
  rmq_post #(.W(W)) u_post (
    .clk(clk), .rst(rst), .en(en),
    .ctl_in(ctl_rc), .s_in(s_rc), .r_in(r_rc), .d_in(d_rc),
    .ctl_out(ctl_po), .q(q)
  );

  assign out_valid = ctl_po.valid;
  assign quat_x    = q[0];
  assign quat_y    = q[1];
  assign quat_z    = q[2];
  assign quat_w    = q[3];

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  // the half root placed at the pivot can never be negative
  a_pivot_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q[ctl_po.piv][W-1])
    else $error("pivot component negative");

  // a held output beat freezes the whole pipeline, nothing enters
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
